// File: design/tbp_pkg.sv
// Shared types, constants and helper functions of the tournament branch predictor.
package tbp_pkg;

  localparam int IndexBitsDef   = 11;
  localparam int HistoryBitsDef = 11;
  localparam int CountBitsDef   = 32;

  localparam int AddrW      = 32;
  localparam int CountOutW  = 32;
  localparam int InDataW    = 40;
  localparam int OutDataW   = 40;
  localparam int ResultW    = CountOutW + 3;

  typedef logic [1:0] ctr_t;

  // Two-bit saturating counter codes. For the chooser the upper half
  // selects bimodal and the lower half selects gshare.
  localparam ctr_t CtrStrongNot   = 2'b00;
  localparam ctr_t CtrWeakNot     = 2'b01;
  localparam ctr_t CtrWeakTaken   = 2'b10;
  localparam ctr_t CtrStrongTaken = 2'b11;

  localparam ctr_t PredResetVal    = CtrStrongTaken;
  localparam ctr_t ChooserResetVal = CtrStrongNot;

  // Result word, last field in the lowest bits.
  typedef struct packed {
    logic [CountOutW-1:0] correct_count;
    logic                 correct;
    logic                 used_bimodal;
    logic                 predicted_taken;
  } result_t;

  function automatic logic ctr_high(ctr_t c);
    return c[1];
  endfunction

  function automatic ctr_t ctr_train(ctr_t c, logic up);
    ctr_t r;
    r = c;
    if (up && (c != CtrStrongTaken)) begin
      r = ctr_t'(c + 2'd1);
    end else if (!up && (c != CtrStrongNot)) begin
      r = ctr_t'(c - 2'd1);
    end
    return r;
  endfunction

endpackage

// File: design/tbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module tbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/tournament_branch_predictor_unit.sv
// Top level of the tournament (bimodal plus gshare) branch predictor.
// Each input word is one resolved branch; each output word gives the chosen
// prediction, the side used, whether it was right and the running hit count.
// One word is accepted per cycle while the output queue has room. The counters
// are read into stage 1 and the result word is registered into the output queue;
// each branch read-modify-writes the three counter RAMs, with the last write
// forwarded to the next branch. After reset a clearing pass over all 2^INDEX_BITS
// entries loads the RAMs with start values; s_axis_tready_o stays low until it ends.
module tournament_branch_predictor_unit #(
  parameter int INDEX_BITS   = tbp_pkg::IndexBitsDef,
  parameter int HISTORY_BITS = tbp_pkg::HistoryBitsDef,
  parameter int COUNT_BITS   = tbp_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid_i,
  output logic                         s_axis_tready_o,
  // [31:0] branch_address, [32] taken, [39:33] zero
  input  logic [tbp_pkg::InDataW-1:0]  s_axis_tdata_i,
  output logic                         m_axis_tvalid_o,
  input  logic                         m_axis_tready_i,
  // [0] predicted_taken, [1] used_bimodal, [2] correct, [34:3] correct_count,
  // [39:35] zero
  output logic [tbp_pkg::OutDataW-1:0] m_axis_tdata_o
);

  localparam int Depth = 1 << INDEX_BITS;

  // Input side.
  logic                  in_acc;
  logic [INDEX_BITS-1:0] bi_in;
  logic [INDEX_BITS-1:0] gi_in;
  logic                  in_taken;

  logic [HISTORY_BITS-1:0] hist_q, hist_d;

  // Stage 1: RAM data arrives here.
  logic                  s1_valid_q;
  logic [INDEX_BITS-1:0] s1_bi_q, s1_gi_q;
  logic                  s1_taken_q;

  // Last write, forwarded to the following branch.
  logic                  fwd_vld_q;
  logic [INDEX_BITS-1:0] fwd_bi_q, fwd_gi_q;
  tbp_pkg::ctr_t         fwd_bim_q, fwd_gsh_q, fwd_cho_q;

  tbp_pkg::ctr_t bim_rdata, gsh_rdata, cho_rdata;
  tbp_pkg::ctr_t bctr, gctr, sel;
  tbp_pkg::ctr_t bim_new, gsh_new, cho_new;
  logic          bpred, gpred, use_bi, pred, hit, b_ok, g_ok;

  logic [COUNT_BITS-1:0] hit_q, hit_d;

  // Clearing pass.
  logic                  clr_busy_q;
  logic [INDEX_BITS-1:0] clr_idx_q;

  // RAM write port.
  logic                  ram_we;
  logic [INDEX_BITS-1:0] wa_bi, wa_gi;
  tbp_pkg::ctr_t         wd_bim, wd_gsh, wd_cho;

  // Two-word output queue.
  tbp_pkg::result_t fifo_q [2];
  tbp_pkg::result_t res;
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;
  logic [1:0] occ, occ_after;

  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign bi_in    = s_axis_tdata_i[INDEX_BITS-1:0];
  assign in_taken = s_axis_tdata_i[tbp_pkg::AddrW];
  assign gi_in    = bi_in ^ INDEX_BITS'(hist_q);
  assign hist_d   = HISTORY_BITS'({hist_q, in_taken});

  assign pop       = m_axis_tvalid_o & m_axis_tready_i;
  assign occ       = cnt_q + {1'b0, s1_valid_q};
  assign occ_after = occ - {1'b0, pop};
  assign s_axis_tready_o = !clr_busy_q && (occ_after < 2'd2);

  tbp_ram #(.WIDTH(2), .DEPTH(Depth)) u_bim_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa_bi),
    .wdata_i (wd_bim),
    .raddr_i (bi_in),
    .rdata_o (bim_rdata)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(Depth)) u_gsh_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa_gi),
    .wdata_i (wd_gsh),
    .raddr_i (gi_in),
    .rdata_o (gsh_rdata)
  );

  tbp_ram #(.WIDTH(2), .DEPTH(Depth)) u_cho_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wa_bi),
    .wdata_i (wd_cho),
    .raddr_i (bi_in),
    .rdata_o (cho_rdata)
  );

  // Prediction and training of the branch in stage 1.
  always_comb begin
    bctr = (fwd_vld_q && (fwd_bi_q == s1_bi_q)) ? fwd_bim_q : bim_rdata;
    sel  = (fwd_vld_q && (fwd_bi_q == s1_bi_q)) ? fwd_cho_q : cho_rdata;
    gctr = (fwd_vld_q && (fwd_gi_q == s1_gi_q)) ? fwd_gsh_q : gsh_rdata;

    bpred  = tbp_pkg::ctr_high(bctr);
    gpred  = tbp_pkg::ctr_high(gctr);
    use_bi = tbp_pkg::ctr_high(sel);
    pred   = use_bi ? bpred : gpred;
    hit    = (pred == s1_taken_q);
    b_ok   = (bpred == s1_taken_q);
    g_ok   = (gpred == s1_taken_q);

    bim_new = tbp_pkg::ctr_train(bctr, s1_taken_q);
    gsh_new = tbp_pkg::ctr_train(gctr, s1_taken_q);
    // The chooser only moves when exactly one side was right.
    cho_new = (b_ok != g_ok) ? tbp_pkg::ctr_train(sel, b_ok) : sel;

    hit_d = hit_q;
    if (s1_valid_q && hit && !(&hit_q)) begin
      hit_d = hit_q + COUNT_BITS'(1);
    end

    res.predicted_taken = pred;
    res.used_bimodal    = use_bi;
    res.correct         = hit;
    res.correct_count   = tbp_pkg::CountOutW'(hit_d);
  end

  always_comb begin
    ram_we = s1_valid_q | clr_busy_q;
    if (clr_busy_q) begin
      wa_bi  = clr_idx_q;
      wa_gi  = clr_idx_q;
      wd_bim = tbp_pkg::PredResetVal;
      wd_gsh = tbp_pkg::PredResetVal;
      wd_cho = tbp_pkg::ChooserResetVal;
    end else begin
      wa_bi  = s1_bi_q;
      wa_gi  = s1_gi_q;
      wd_bim = bim_new;
      wd_gsh = gsh_new;
      wd_cho = cho_new;
    end
  end

  assign cnt_d = cnt_q + {1'b0, s1_valid_q} - {1'b0, pop};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_idx_q  <= '0;
      hist_q     <= '0;
      hit_q      <= '0;
      s1_valid_q <= 1'b0;
      fwd_vld_q  <= 1'b0;
      cnt_q      <= '0;
      wr_ptr_q   <= 1'b0;
      rd_ptr_q   <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + INDEX_BITS'(1);
        if (&clr_idx_q) begin
          clr_busy_q <= 1'b0;
        end
      end
      if (in_acc) begin
        hist_q <= hist_d;
      end
      hit_q      <= hit_d;
      s1_valid_q <= in_acc;
      fwd_vld_q  <= s1_valid_q;
      cnt_q      <= cnt_d;
      if (s1_valid_q) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_bi_q    <= bi_in;
      s1_gi_q    <= gi_in;
      s1_taken_q <= in_taken;
    end
    if (s1_valid_q) begin
      fwd_bi_q           <= s1_bi_q;
      fwd_gi_q           <= s1_gi_q;
      fwd_bim_q          <= bim_new;
      fwd_gsh_q          <= gsh_new;
      fwd_cho_q          <= cho_new;
      fifo_q[wr_ptr_q]   <= res;
    end
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = {{(tbp_pkg::OutDataW - tbp_pkg::ResultW){1'b0}}, fifo_q[rd_ptr_q]};

  // No branch enters while the tables are being cleared.
  a_no_accept_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> (!s_axis_tready_o && !s1_valid_q))
    else $error("branch accepted during clearing pass");

  // The output queue can always take the branch in stage 1.
  a_queue_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q + {1'b0, s1_valid_q}) <= 2'd2)
    else $error("output queue overflow");

  // The hit count never goes down.
  a_hit_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> (hit_q >= $past(hit_q)))
    else $error("hit count decreased");

  // History only shifts when a branch is accepted.
  a_hist_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_acc |=> $stable(hist_q))
    else $error("history changed without a branch");

endmodule

// File: tb/tbp_checker.sv
// Checker that predicts every result word of the branch predictor and compares it.
`timescale 1ns / 1ps

module tbp_checker #(
  parameter int INDEX_BITS   = tbp_pkg::IndexBitsDef,
  parameter int HISTORY_BITS = tbp_pkg::HistoryBitsDef,
  parameter int COUNT_BITS   = tbp_pkg::CountBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic [tbp_pkg::InDataW-1:0]  in_data_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic [tbp_pkg::OutDataW-1:0] out_data_i,
  output int                           fail_count_o,
  output int                           pending_o,
  output int                           checked_o,
  output int                           bimodal_picks_o
);

  localparam int TableDepth = 1 << INDEX_BITS;
  localparam int ExpDepth   = 64;

  tbp_pkg::ctr_t           bim_tbl     [TableDepth];
  tbp_pkg::ctr_t           gsh_tbl     [TableDepth];
  tbp_pkg::ctr_t           chooser_tbl [TableDepth];
  logic [HISTORY_BITS-1:0] ghist;
  logic [COUNT_BITS-1:0]   hits;
  // Expected result words in order, kept as a ring buffer.
  tbp_pkg::result_t        exp_buf     [ExpDepth];
  logic [5:0]              exp_wr;
  logic [5:0]              exp_rd;
  int                      exp_cnt;
  int                      fails;
  int                      checked;
  int                      bim_picks;

  // Two-bit saturating step toward the given direction.
  function automatic tbp_pkg::ctr_t sat_step(tbp_pkg::ctr_t c, logic up);
    if (up) begin
      return (c == tbp_pkg::CtrStrongTaken) ? c : tbp_pkg::ctr_t'(c + 1);
    end
    return (c == tbp_pkg::CtrStrongNot) ? c : tbp_pkg::ctr_t'(c - 1);
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] want,
                                 input logic [63:0] got);
    $display("MISMATCH at result %0d, %s: expected %0h, got %0h", checked, what, want, got);
    fails++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : track
    logic [tbp_pkg::AddrW-1:0] addr;
    logic                      outcome;
    logic [INDEX_BITS-1:0]     bi;
    logic [INDEX_BITS-1:0]     gi;
    tbp_pkg::ctr_t             bctr;
    tbp_pkg::ctr_t             gctr;
    tbp_pkg::ctr_t             sel;
    logic                      bpred;
    logic                      gpred;
    tbp_pkg::result_t          want;
    tbp_pkg::result_t          got;

    if (!rst_ni) begin
      for (int i = 0; i < TableDepth; i++) begin
        bim_tbl[i]     = tbp_pkg::PredResetVal;
        gsh_tbl[i]     = tbp_pkg::PredResetVal;
        chooser_tbl[i] = tbp_pkg::ChooserResetVal;
      end
      ghist     = '0;
      hits      = '0;
      exp_wr    = '0;
      exp_rd    = '0;
      exp_cnt   = 0;
      fails     = 0;
      checked   = 0;
      bim_picks = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (exp_cnt == 0) begin
          report_mismatch("result word with no branch pending", '0, 64'(out_data_i));
        end else begin
          want    = exp_buf[exp_rd];
          exp_rd  = exp_rd + 6'd1;
          exp_cnt = exp_cnt - 1;
          got     = tbp_pkg::result_t'(out_data_i[tbp_pkg::ResultW-1:0]);
          if (got.predicted_taken !== want.predicted_taken) begin
            report_mismatch("predicted_taken", 64'(want.predicted_taken),
                            64'(got.predicted_taken));
          end
          if (got.used_bimodal !== want.used_bimodal) begin
            report_mismatch("used_bimodal", 64'(want.used_bimodal), 64'(got.used_bimodal));
          end
          if (got.correct !== want.correct) begin
            report_mismatch("correct", 64'(want.correct), 64'(got.correct));
          end
          if (got.correct_count !== want.correct_count) begin
            report_mismatch("correct_count", 64'(want.correct_count),
                            64'(got.correct_count));
          end
          if (out_data_i[tbp_pkg::OutDataW-1:tbp_pkg::ResultW] !== '0) begin
            report_mismatch("padding bits", '0,
                            64'(out_data_i[tbp_pkg::OutDataW-1:tbp_pkg::ResultW]));
          end
          if (want.used_bimodal) begin
            bim_picks++;
          end
        end
        checked++;
      end

      if (in_valid_i && in_ready_i) begin
        addr    = in_data_i[tbp_pkg::AddrW-1:0];
        outcome = in_data_i[tbp_pkg::AddrW];
        bi      = addr[INDEX_BITS-1:0];
        // History is zero-extended or truncated to the index width.
        gi      = bi ^ INDEX_BITS'(ghist);
        bctr    = bim_tbl[bi];
        gctr    = gsh_tbl[gi];
        sel     = chooser_tbl[bi];
        bpred   = bctr[1];
        gpred   = gctr[1];

        want.used_bimodal    = sel[1];
        want.predicted_taken = sel[1] ? bpred : gpred;
        want.correct         = (want.predicted_taken == outcome);
        if (want.correct && (hits != '1)) begin
          hits = hits + 1'b1;
        end
        want.correct_count = tbp_pkg::CountOutW'(hits);
        if (exp_cnt == ExpDepth) begin
          report_mismatch("too many branches pending", 64'(ExpDepth), 64'(exp_cnt));
        end else begin
          exp_buf[exp_wr] = want;
          exp_wr          = exp_wr + 6'd1;
          exp_cnt         = exp_cnt + 1;
        end

        bim_tbl[bi] = sat_step(bctr, outcome);
        gsh_tbl[gi] = sat_step(gctr, outcome);
        ghist       = HISTORY_BITS'({ghist, outcome});
        // The chooser only moves when exactly one side was right.
        if ((bpred == outcome) && (gpred != outcome)) begin
          chooser_tbl[bi] = sat_step(sel, 1'b1);
        end else if ((gpred == outcome) && (bpred != outcome)) begin
          chooser_tbl[bi] = sat_step(sel, 1'b0);
        end
      end
    end
    fail_count_o    <= fails;
    pending_o       <= exp_cnt;
    checked_o       <= checked;
    bimodal_picks_o <= bim_picks;
  end

endmodule

// File: tb/tb_tournament_branch_predictor_unit.sv
// Top of the branch predictor testbench: clock, reset, stimulus, watchdog and verdict.
`timescale 1ns / 1ps

module tb_tournament_branch_predictor_unit;

  localparam int RandomItems = 1050;
  localparam int IdleLimit   = 20000;
  localparam int StallCycles = 300;
  localparam int HotCount    = 8;

  logic                         clk_i   = 1'b0;
  logic                         rst_ni  = 1'b0;
  logic                         s_valid = 1'b0;
  logic                         s_ready;
  logic [tbp_pkg::InDataW-1:0]  s_data  = '0;
  logic                         m_valid;
  logic                         m_ready = 1'b0;
  logic [tbp_pkg::OutDataW-1:0] m_data;

  int fails;
  int pending;
  int checked;
  int bim_picks;
  int sent = 0;

  always #10 clk_i = ~clk_i;

  tournament_branch_predictor_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_data),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_data)
  );

  tbp_checker checker_i (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (s_valid),
    .in_ready_i     (s_ready),
    .in_data_i      (s_data),
    .out_valid_i    (m_valid),
    .out_ready_i    (m_ready),
    .out_data_i     (m_data),
    .fail_count_o   (fails),
    .pending_o      (pending),
    .checked_o      (checked),
    .bimodal_picks_o(bim_picks)
  );

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : $urandom_range(0, 16);
  endfunction

  task automatic send_branch(input logic [tbp_pkg::AddrW-1:0] addr, input logic tkn,
                             input int gap);
    repeat (gap) begin
      @(negedge clk_i);
      s_valid <= 1'b0;
    end
    @(negedge clk_i);
    s_valid <= 1'b1;
    s_data  <= {{(tbp_pkg::InDataW-tbp_pkg::AddrW-1){1'b0}}, tkn, addr};
    do @(posedge clk_i); while (!(s_valid && s_ready));
    sent++;
  endtask

  // Result side: random hold-offs per word, quiet phases, and one long stall.
  initial begin : receiver
    int  rcv;
    bit  calm;
    rcv = 0;
    @(posedge rst_ni);
    forever begin
      calm = ((rcv / 150) % 4) == 2;
      if (rcv == 400) begin
        repeat (StallCycles) begin
          @(negedge clk_i);
          m_ready <= 1'b0;
        end
      end else begin
        repeat (draw_gap(calm)) begin
          @(negedge clk_i);
          m_ready <= 1'b0;
        end
      end
      @(negedge clk_i);
      m_ready <= 1'b1;
      do @(posedge clk_i); while (!(m_valid && m_ready));
      rcv++;
    end
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if ((s_valid && s_ready) || (m_valid && m_ready)) begin
        idle = 0;
      end else begin
        idle++;
      end
    end
    $display("Timeout: no word moved for %0d cycles", IdleLimit);
    $display("tournament_branch_predictor_unit test failed");
    $finish;
  end

  initial begin : stimulus
    logic [tbp_pkg::AddrW-1:0] hot_addr [HotCount];
    logic [15:0]               hot_pat  [HotCount];
    int                        hot_len  [HotCount];
    int                        hot_iter [HotCount];
    logic [tbp_pkg::AddrW-1:0] addr;
    logic                      tkn;
    int                        j;
    int                        kind;
    int                        directed;
    bit                        calm;

    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;

    // Extremes of the address, aliasing through the high bits, both outcomes.
    send_branch(32'h0000_0000, 1'b1, draw_gap(0));
    send_branch(32'h0000_0000, 1'b0, draw_gap(0));
    send_branch(32'hFFFF_FFFF, 1'b0, draw_gap(0));
    send_branch(32'hFFFF_F800, 1'b1, draw_gap(0));
    send_branch(32'h0000_07FF, 1'b1, draw_gap(0));
    send_branch(32'h0000_0800, 1'b0, draw_gap(0));
    send_branch(32'h8000_0000, 1'b1, draw_gap(0));
    send_branch(32'h7FFF_FFFF, 1'b0, draw_gap(0));
    send_branch(32'hAAAA_AAAA, 1'b1, draw_gap(0));
    send_branch(32'h5555_5555, 1'b0, draw_gap(0));
    // An alternating branch makes the two sides disagree and moves the chooser.
    for (int i = 0; i < 10; i++) begin
      send_branch(32'h0000_0040, i[0] ? 1'b0 : 1'b1, draw_gap(i < 5));
    end
    send_branch(32'hDEAD_B840, 1'b1, draw_gap(0));
    directed = sent;

    for (int k = 0; k < RandomItems; k++) begin
      if ((k % 200) == 0) begin
        for (int h = 0; h < HotCount; h++) begin
          hot_addr[h] = $urandom();
          hot_pat[h]  = 16'($urandom());
          hot_len[h]  = $urandom_range(1, 8);
          hot_iter[h] = 0;
        end
      end
      kind = $urandom_range(0, 9);
      j    = $urandom_range(0, HotCount - 1);
      if (kind < 7) begin
        // Loop-like branches with a repeating outcome pattern.
        addr = hot_addr[j];
        tkn  = hot_pat[j][hot_iter[j] % hot_len[j]];
        hot_iter[j]++;
      end else if (kind == 7) begin
        addr = {21'($urandom_range(0, 2097151)), hot_addr[j][10:0]};
        tkn  = 1'($urandom_range(0, 1));
      end else begin
        addr = $urandom();
        tkn  = 1'($urandom_range(0, 1));
      end
      // Back-to-back words around the long output stall so the block fills up.
      calm = (((k / 150) % 4) == 1) || ((k >= 370) && (k < 520));
      send_branch(addr, tkn, draw_gap(calm));
    end
    @(negedge clk_i);
    s_valid <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);

    $display("Sent %0d branches (%0d directed, rest looped, aliased and random).",
             sent, directed);
    $display("Checked %0d result words; bimodal was chosen %0d times.", checked, bim_picks);
    if (fails == 0) begin
      $display("tournament_branch_predictor_unit test passed");
    end else begin
      $display("tournament_branch_predictor_unit test failed");
    end
    $finish;
  end

endmodule
